>>> src/pbre_pkg.sv
package pbre_pkg;

    // Defaults for the module parameters.
    localparam int DEF_MAX_LAYERS   = 64;
    localparam int DEF_MAX_SECTORS  = 64;
    localparam int DEF_COORD_BITS   = 24;
    localparam int DEF_CORDIC_STEPS = 16;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int IDX_OUT_W = 6;
    localparam int RAD_OUT_W = 24;
    localparam int CELL_W    = 25;
    localparam int ANGLE_W   = 24;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int COUNT_W   = 7;
    localparam int SCALE_W   = 32;
    localparam int HEIGHT_W  = 23;
    localparam int MARGIN_W  = 16;

    localparam logic [CELL_W-1:0]  CELL_MAX  = {CELL_W{1'b1}};
    localparam logic [ANGLE_W-1:0] HALF_TURN = 24'h800000;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS   = 3'd5;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0]  RST_LAYER_COUNT  = 7'd8;
    localparam logic [COUNT_W-1:0]  RST_SECTOR_COUNT = 7'd8;
    localparam logic [SCALE_W-1:0]  RST_LAYER_SCALE  = 32'd65536;
    localparam logic [HEIGHT_W-1:0] RST_MAX_HEIGHT   = 23'd8388607;
    localparam logic [MARGIN_W-1:0] RST_MARGIN       = 16'd51;
    localparam logic [MARGIN_W-1:0] RST_MIN_RADIUS   = 16'd256;

    // Arctangent of 2^-i in units of 2^-24 turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:  v = 24'd2097152;
            5'd1:  v = 24'd1238021;
            5'd2:  v = 24'd654136;
            5'd3:  v = 24'd332050;
            5'd4:  v = 24'd166669;
            5'd5:  v = 24'd83416;
            5'd6:  v = 24'd41718;
            5'd7:  v = 24'd20860;
            5'd8:  v = 24'd10430;
            5'd9:  v = 24'd5215;
            5'd10: v = 24'd2608;
            5'd11: v = 24'd1304;
            5'd12: v = 24'd652;
            5'd13: v = 24'd326;
            5'd14: v = 24'd163;
            5'd15: v = 24'd81;
            5'd16: v = 24'd41;
            5'd17: v = 24'd20;
            5'd18: v = 24'd10;
            5'd19: v = 24'd5;
            5'd20: v = 24'd3;
            5'd21: v = 24'd1;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // Zero acts as one, values above the maximum act as the maximum.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] maxc);
        logic [CNT_W-1:0] v;
        v = CNT_W'(c);
        if (c == '0) begin
            v = CNT_W'(1);
        end else if (v > maxc) begin
            v = maxc;
        end
        return v;
    endfunction

endpackage

>>> src/pbre_cordic.sv
module pbre_cordic #(
    parameter int COORD_BITS   = pbre_pkg::DEF_COORD_BITS,
    parameter int CORDIC_STEPS = pbre_pkg::DEF_CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [COORD_BITS-1:0]      i_x,
    input  logic signed [COORD_BITS-1:0]      i_z,
    output logic                              o_done,
    output logic [pbre_pkg::ANGLE_W-1:0]      o_angle
);
    import pbre_pkg::*;

    localparam int VW = COORD_BITS + 3;
    localparam int IW = $clog2(CORDIC_STEPS + 1);

    logic                 r_run;
    logic [IW-1:0]        r_i;
    logic signed [VW-1:0] r_a;
    logic signed [VW-1:0] r_b;
    logic [ANGLE_W-1:0]   r_acc;
    logic signed [VW-1:0] da;
    logic signed [VW-1:0] db;
    logic [ANGLE_W-1:0]   step_angle;

    // One rotation per cycle, shift amount set by the iteration count.
    always_comb begin
        da         = r_b >>> r_i;
        db         = r_a >>> r_i;
        step_angle = atan_turn(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && r_i == IW'(CORDIC_STEPS - 1)) begin
            r_run <= 1'b0;
        end
    end

    // Vector state: fold the left half plane first, then iterate.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i <= '0;
            if (i_z < 0) begin
                r_a   <= -VW'(i_z);
                r_b   <= -VW'(i_x);
                r_acc <= HALF_TURN;
            end else begin
                r_a   <= VW'(i_z);
                r_b   <= VW'(i_x);
                r_acc <= '0;
            end
        end else if (r_run) begin
            r_i <= r_i + 1'b1;
            if (r_b >= 0) begin
                r_a   <= r_a + da;
                r_b   <= r_b - db;
                r_acc <= r_acc + step_angle;
            end else begin
                r_a   <= r_a - da;
                r_b   <= r_b + db;
                r_acc <= r_acc - step_angle;
            end
        end
    end

    assign o_done  = !r_run;
    assign o_angle = r_acc;

endmodule

>>> src/pbre_radius.sv
module pbre_radius #(
    parameter int COORD_BITS = pbre_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_z,
    output logic                          o_done,
    output logic [COORD_BITS-1:0]         o_root
);
    import pbre_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int SW = 2 * N;
    localparam int RW = N + 3;
    localparam int KW = $clog2(N + 1);

    typedef enum logic [1:0] {P_IDLE, P_SQX, P_SQZ, P_ITER} t_phase;

    t_phase                r_phase;
    logic [KW-1:0]         r_k;
    logic signed [N-1:0]   r_x;
    logic signed [N-1:0]   r_z;
    logic [SW-1:0]         r_sum;
    logic [RW-1:0]         r_rem;
    logic [N-1:0]          r_root;
    logic signed [N-1:0]   mul_op;
    logic [SW-1:0]         square;
    logic [RW-1:0]         rem_ext;
    logic [RW-1:0]         trial;

    // One shared multiplier squares x, then z.
    always_comb begin
        mul_op  = (r_phase == P_SQX) ? r_x : r_z;
        square  = SW'(mul_op * mul_op);
        rem_ext = {r_rem[N:0], r_sum[SW-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
        end else begin
            case (r_phase)
                P_IDLE: if (i_start) r_phase <= P_SQX;
                P_SQX:  r_phase <= P_SQZ;
                P_SQZ:  r_phase <= P_ITER;
                P_ITER: if (r_k == KW'(N - 1)) r_phase <= P_IDLE;
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    // Restoring square root, one result bit per cycle.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_x <= i_x;
                    r_z <= i_z;
                end
            end
            P_SQX: begin
                r_sum <= square;
            end
            P_SQZ: begin
                r_sum  <= r_sum + square;
                r_rem  <= '0;
                r_root <= '0;
                r_k    <= '0;
            end
            P_ITER: begin
                r_sum <= {r_sum[SW-3:0], 2'b00};
                r_k   <= r_k + 1'b1;
                if (rem_ext >= trial) begin
                    r_rem  <= rem_ext - trial;
                    r_root <= {r_root[N-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_ext;
                    r_root <= {r_root[N-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_phase == P_IDLE);
    assign o_root = r_root;

endmodule

>>> src/pbre_table.sv
module pbre_table #(
    parameter int DEPTH = pbre_pkg::DEF_MAX_LAYERS * pbre_pkg::DEF_MAX_SECTORS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [pbre_pkg::CELL_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [pbre_pkg::CELL_W-1:0]   i_wr_data
);
    import pbre_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/polar_bin_radius_envelope.sv
// An insert or a built-table query runs the CORDIC and the bit-serial square root, then selects
// the bin, reads the table cell and strobes o_valid; an early query or unused mode skips the read.
// An insert near the axis reads and writes back every sector in use in its layer, one after the
// other; a clear sweeps every cell of the table to zero before its o_valid strobe.
// Throughput: one item at a time; busy stays high until the result beat, which cannot stall.
// Reset: synchronous, active low; then the table is swept to zero, busy high for the sweep.
module polar_bin_radius_envelope #(
    parameter int MAX_LAYERS   = pbre_pkg::DEF_MAX_LAYERS,
    parameter int MAX_SECTORS  = pbre_pkg::DEF_MAX_SECTORS,
    parameter int COORD_BITS   = pbre_pkg::DEF_COORD_BITS,
    parameter int CORDIC_STEPS = pbre_pkg::DEF_CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pbre_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [COORD_BITS-1:0]      i_x_coord,
    input  logic signed [COORD_BITS-1:0]      i_y_coord,
    input  logic signed [COORD_BITS-1:0]      i_z_coord,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pbre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbre_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic                              o_in_volume,
    output logic [pbre_pkg::IDX_OUT_W-1:0]    o_layer_index,
    output logic [pbre_pkg::IDX_OUT_W-1:0]    o_sector_index,
    output logic [pbre_pkg::RAD_OUT_W-1:0]    o_radius
);
    import pbre_pkg::*;

    localparam int DEPTH = MAX_LAYERS * MAX_SECTORS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int N     = COORD_BITS;
    localparam int PW    = N + SCALE_W;
    localparam int CW    = ((N > CELL_W) ? N : CELL_W) + 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_FRONT, S_INDEX, S_READ, S_WAIT} t_state;

    t_state                r_state;
    logic                  r_clr_emit;
    logic                  r_fill;
    logic                  r_built;
    logic                  r_valid;
    logic                  r_in_vol;
    logic [AW-1:0]         r_clr_addr;
    logic [MODE_W-1:0]     r_mode;
    logic signed [N-1:0]   r_x;
    logic signed [N-1:0]   r_y;
    logic signed [N-1:0]   r_z;
    logic [PW-1:0]         r_lprod;
    logic [LW-1:0]         r_layer;
    logic [SW-1:0]         r_sector;
    logic [SW-1:0]         r_fill_sec;

    logic [COUNT_W-1:0]    r_layer_count;
    logic [COUNT_W-1:0]    r_sector_count;
    logic [SCALE_W-1:0]    r_layer_scale;
    logic [HEIGHT_W-1:0]   r_max_height;
    logic [MARGIN_W-1:0]   r_margin;
    logic [MARGIN_W-1:0]   r_min_radius;

    logic                  accept;
    logic                  cordic_done;
    logic                  rad_done;
    logic [ANGLE_W-1:0]    angle;
    logic [N-1:0]          root;
    logic [CNT_W-1:0]      lc;
    logic [CNT_W-1:0]      sc;
    logic [PW-25:0]        lshift;
    logic [LW-1:0]         layer_n;
    logic [ANGLE_W-1:0]    u;
    logic [ANGLE_W+CNT_W-1:0] uprod;
    logic [CNT_W-1:0]      q;
    logic [SW-1:0]         sector_n;
    logic [CW-1:0]         r_ext;
    logic [CW-1:0]         padded_sum;
    logic [CELL_W-1:0]     padded;
    logic [CW-1:0]         cell_ext;
    logic [CW-1:0]         lim;
    logic                  near_axis;
    logic [AW-1:0]         cell_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [CELL_W-1:0]     wr_data;
    logic [CELL_W-1:0]     rd_data;
    logic                  height_ok;
    logic                  last_sec;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count  <= RST_LAYER_COUNT;
            r_sector_count <= RST_SECTOR_COUNT;
            r_layer_scale  <= RST_LAYER_SCALE;
            r_max_height   <= RST_MAX_HEIGHT;
            r_margin       <= RST_MARGIN;
            r_min_radius   <= RST_MIN_RADIUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAYER_COUNT:  r_layer_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data[COUNT_W-1:0];
                CFG_LAYER_SCALE:  r_layer_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_MAX_HEIGHT:   r_max_height   <= i_cfg_data[HEIGHT_W-1:0];
                CFG_MARGIN:       r_margin       <= i_cfg_data[MARGIN_W-1:0];
                CFG_MIN_RADIUS:   r_min_radius   <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    pbre_cordic #(
        .COORD_BITS  (COORD_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_x    (i_x_coord),
        .i_z    (i_z_coord),
        .o_done (cordic_done),
        .o_angle(angle)
    );

    pbre_radius #(
        .COORD_BITS(COORD_BITS)
    ) u_radius (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_x    (i_x_coord),
        .i_z    (i_z_coord),
        .o_done (rad_done),
        .o_root (root)
    );

    pbre_table #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(cell_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    // Layer selection from the registered layer product, sector selection from the angle.
    always_comb begin
        lc     = clamp_count(r_layer_count, CNT_W'(MAX_LAYERS));
        sc     = clamp_count(r_sector_count, CNT_W'(MAX_SECTORS));
        lshift = r_lprod[PW-1:24];
        if (r_y < 0) begin
            layer_n = '0;
        end else if (lshift >= (PW-24)'(lc)) begin
            layer_n = LW'(lc - 1'b1);
        end else begin
            layer_n = LW'(lshift);
        end
        u     = angle + HALF_TURN;
        uprod = u * sc;
        q     = CNT_W'(uprod[ANGLE_W+CNT_W-1:ANGLE_W]);
        if (r_x == 0 && r_z == 0) begin
            sector_n = '0;
        end else if (r_x == 0 && r_z < 0) begin
            sector_n = SW'(sc - 1'b1);
        end else if (q >= sc) begin
            sector_n = SW'(sc - 1'b1);
        end else begin
            sector_n = SW'(q);
        end
    end

    // Radius arithmetic: padded value saturates at the cell maximum.
    always_comb begin
        r_ext      = CW'(root);
        padded_sum = r_ext + CW'(r_margin);
        padded     = (padded_sum > CW'(CELL_MAX)) ? CELL_MAX : CELL_W'(padded_sum);
        near_axis  = (r_ext <= CW'(r_margin));
        cell_ext   = CW'(rd_data);
        lim        = (cell_ext < CW'(r_min_radius)) ? CW'(r_min_radius) : cell_ext;
        height_ok  = (r_y < 0) || (CW'(r_y) <= CW'(r_max_height));
        last_sec   = (CNT_W'(r_fill_sec) == sc - 1'b1);
    end

    // Table access: one read per visit, write back in the data cycle.
    always_comb begin
        cell_addr = AW'(r_layer * MAX_SECTORS + (r_fill ? r_fill_sec : r_sector));
        rd_en     = (r_state == S_READ);
        wr_en     = 1'b0;
        wr_addr   = cell_addr;
        wr_data   = padded;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (r_state == S_WAIT && r_mode == MODE_INSERT) begin
            if (r_fill) begin
                wr_en = (rd_data < padded);
            end else begin
                wr_en = (cell_ext < r_ext);
            end
        end
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_emit <= 1'b0;
            r_built    <= 1'b0;
            r_valid    <= 1'b0;
            r_fill     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_lprod <= PW'(N'(r_y) * r_layer_scale);
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_clr_addr <= '0;
                        r_built    <= 1'b0;
                        r_valid    <= r_clr_emit;
                        r_clr_emit <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_mode;
                        r_x     <= i_x_coord;
                        r_y     <= i_y_coord;
                        r_z     <= i_z_coord;
                        r_state <= S_FRONT;
                    end
                end
                S_FRONT: begin
                    if (cordic_done && rad_done) begin
                        r_state <= S_INDEX;
                    end
                end
                S_INDEX: begin
                    r_layer    <= layer_n;
                    r_sector   <= sector_n;
                    r_in_vol   <= 1'b0;
                    r_fill     <= 1'b0;
                    r_fill_sec <= '0;
                    case (r_mode)
                        MODE_CLEAR: begin
                            r_clr_emit <= 1'b1;
                            r_state    <= S_CLEAR;
                        end
                        MODE_INSERT: begin
                            r_fill  <= near_axis;
                            r_state <= S_READ;
                        end
                        MODE_QUERY: begin
                            if (r_built) begin
                                r_state <= S_READ;
                            end else begin
                                r_in_vol <= 1'b1;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                        default: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_mode == MODE_QUERY) begin
                        r_in_vol <= (lim >= r_ext) && height_ok;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_fill && !last_sec) begin
                        r_fill_sec <= r_fill_sec + 1'b1;
                        r_state    <= S_READ;
                    end else begin
                        r_built <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_in_volume    = r_in_vol;
    assign o_layer_index  = IDX_OUT_W'(LW'(r_layer));
    assign o_sector_index = IDX_OUT_W'(SW'(r_sector));
    assign o_radius       = RAD_OUT_W'(r_ext);

`ifndef NO_ASSERTIONS
    // A result beat is a single-cycle strobe.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("block not busy after accepting an item");

    // Only queries can report a point inside the envelope.
    a_vol_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_volume) |-> (r_mode == MODE_QUERY))
        else $error("in_volume set on a non-query result");

    // Table writes come only from the clearing sweep or an insert write back.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR || (r_state == S_WAIT && r_mode == MODE_INSERT)))
        else $error("unexpected table write");
`endif

endmodule

>>> bench/polar_bin_radius_envelope_test.sv
`timescale 1ns / 100ps

module polar_bin_radius_envelope_test;
    import pbre_pkg::*;

    localparam int NL = DEF_MAX_LAYERS;
    localparam int NS = DEF_MAX_SECTORS;
    localparam int CB = DEF_COORD_BITS;

    // Mode code that the block leaves unused.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                 in_volume;
        logic [IDX_OUT_W-1:0] layer;
        logic [IDX_OUT_W-1:0] sector;
        logic [RAD_OUT_W-1:0] radius;
    } t_bin_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode;
    logic signed [CB-1:0] i_x_coord;
    logic signed [CB-1:0] i_y_coord;
    logic signed [CB-1:0] i_z_coord;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_valid;
    logic                 o_in_volume;
    logic [IDX_OUT_W-1:0] o_layer_index;
    logic [IDX_OUT_W-1:0] o_sector_index;
    logic [RAD_OUT_W-1:0] o_radius;

    // Shadow of the envelope table and the register file.
    logic [CELL_W-1:0]   envelope [0:NL*NS-1];
    logic                envelope_built;
    logic [COUNT_W-1:0]  layer_count_q, sector_count_q;
    logic [SCALE_W-1:0]  layer_scale_q;
    logic [HEIGHT_W-1:0] max_height_q;
    logic [MARGIN_W-1:0] margin_q, min_radius_q;

    t_bin_answer pending_answers [$];
    int          fail_count = 0;
    bit          idling_on = 1'b1;
    logic signed [CB-1:0] last_x = '0, last_y = '0, last_z = '0;

    polar_bin_radius_envelope dut (.*);

    // Clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Vectoring rotation giving atan2(x, z) in 2^-24 turn units.
    function automatic logic [ANGLE_W-1:0] polar_angle(input longint x, input longint z);
        longint a, b, da, db;
        logic [ANGLE_W-1:0] acc;
        a = z;
        b = x;
        acc = '0;
        if (a < 0) begin
            a = -a;
            b = -b;
            acc = HALF_TURN;
        end
        for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a += da;
                b -= db;
                acc = acc + atan_turn(5'(i));
            end else begin
                a -= da;
                b += db;
                acc = acc - atan_turn(5'(i));
            end
        end
        return acc;
    endfunction

    // Bins one point, updates the shadow table and returns the expected answer.
    function automatic t_bin_answer bin_point(input logic [MODE_W-1:0] mode,
                                              input longint x, input longint y,
                                              input longint z);
        longint unsigned lc, sc, lay, sec, r, padded, lim;
        logic [ANGLE_W-1:0] u;
        int slot;
        t_bin_answer ans;
        lc = (layer_count_q == 0) ? 1 : (layer_count_q > NL ? NL : layer_count_q);
        sc = (sector_count_q == 0) ? 1 : (sector_count_q > NS ? NS : sector_count_q);
        if (y < 0) begin
            lay = 0;
        end else begin
            lay = (longint'(y) * longint'(layer_scale_q)) >> 24;
            if (lay >= lc) lay = lc - 1;
        end
        if (x == 0 && z == 0) begin
            sec = 0;
        end else if (x == 0 && z < 0) begin
            sec = sc - 1;
        end else begin
            u = polar_angle(x, z) + HALF_TURN;
            sec = (longint'(u) * sc) >> 24;
            if (sec >= sc) sec = sc - 1;
        end
        r = isqrt(x * x + z * z);
        padded = r + margin_q;
        if (padded > CELL_MAX) padded = CELL_MAX;
        slot = int'(lay) * NS + int'(sec);
        ans.in_volume = 1'b0;
        case (mode)
            MODE_CLEAR: begin
                foreach (envelope[i]) envelope[i] = '0;
                envelope_built = 1'b0;
            end
            MODE_INSERT: begin
                if (r <= margin_q) begin
                    for (int s = 0; s < sc; s++) begin
                        if (envelope[int'(lay) * NS + s] < padded)
                            envelope[int'(lay) * NS + s] = CELL_W'(padded);
                    end
                end else if (envelope[slot] < r) begin
                    envelope[slot] = CELL_W'(padded);
                end
                envelope_built = 1'b1;
            end
            MODE_QUERY: begin
                if (!envelope_built) begin
                    ans.in_volume = 1'b1;
                end else begin
                    lim = envelope[slot];
                    if (lim < min_radius_q) lim = min_radius_q;
                    ans.in_volume = (lim >= r) && (y <= longint'(max_height_q));
                end
            end
            default: ;
        endcase
        ans.layer = lay[IDX_OUT_W-1:0];
        ans.sector = sec[IDX_OUT_W-1:0];
        ans.radius = r[RAD_OUT_W-1:0];
        return ans;
    endfunction

    // Result checker: every strobed beat is matched to the oldest expectation.
    always @(posedge i_clk) begin
        t_bin_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat");
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_in_volume !== want.in_volume) begin
                    $error("in_volume exp %0d got %0d", want.in_volume, o_in_volume);
                    fail_count++;
                end
                if (o_layer_index !== want.layer) begin
                    $error("layer_index exp %0d got %0d", want.layer, o_layer_index);
                    fail_count++;
                end
                if (o_sector_index !== want.sector) begin
                    $error("sector_index exp %0d got %0d", want.sector, o_sector_index);
                    fail_count++;
                end
                if (o_radius !== want.radius) begin
                    $error("radius exp %0d got %0d", want.radius, o_radius);
                    fail_count++;
                end
            end
        end
    end

    // Sends one point; start may stay high straight into the next beat.
    task automatic send_point(input logic [MODE_W-1:0] mode, input logic signed [CB-1:0] x,
                              input logic signed [CB-1:0] y, input logic signed [CB-1:0] z);
        if (idling_on && $urandom_range(99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_x_coord <= x;
        i_y_coord <= y;
        i_z_coord <= z;
        do @(posedge i_clk); while (busy);
        pending_answers = {pending_answers, bin_point(mode, x, y, z)};
        if (mode == MODE_INSERT) begin
            last_x = x;
            last_y = y;
            last_z = z;
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LAYER_COUNT:  layer_count_q = val[COUNT_W-1:0];
            CFG_SECTOR_COUNT: sector_count_q = val[COUNT_W-1:0];
            CFG_LAYER_SCALE:  layer_scale_q = val;
            CFG_MAX_HEIGHT:   max_height_q = val[HEIGHT_W-1:0];
            CFG_MARGIN:       margin_q = val[MARGIN_W-1:0];
            CFG_MIN_RADIUS:   min_radius_q = val[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    // Coordinate of varied magnitude: zero, shifted random, full range or an extreme.
    function automatic logic signed [CB-1:0] pick_coord();
        logic signed [CB-1:0] c;
        c = CB'($urandom);
        case ($urandom_range(5))
            0: c = '0;
            1: c = $urandom_range(1) ? {1'b0, {CB-1{1'b1}}} : {1'b1, {CB-1{1'b0}}};
            2: ;
            default: c = c >>> $urandom_range(8, 22);
        endcase
        return c;
    endfunction

    task automatic test_directed();
        send_point(MODE_QUERY, 24'sd512, 24'sd256, 24'sd512);
        send_point(MODE_INSERT, '0, 24'sd300, '0);
        send_point(MODE_INSERT, '0, 24'sd600, -24'sd700);
        send_point(MODE_INSERT, 24'sd20, 24'sd600, -24'sd10);
        send_point(MODE_INSERT, {1'b1, {CB-1{1'b0}}}, {1'b0, {CB-1{1'b1}}},
                   {1'b1, {CB-1{1'b0}}});
        send_point(MODE_INSERT, {1'b0, {CB-1{1'b1}}}, -24'sd5, {1'b0, {CB-1{1'b1}}});
        send_point(MODE_INSERT, 24'sd1000, 24'sd900, 24'sd0);
        send_point(MODE_INSERT, -24'sd1000, 24'sd900, 24'sd1);
        send_point(MODE_QUERY, 24'sd900, 24'sd900, 24'sd0);
        send_point(MODE_QUERY, 24'sd3000, 24'sd900, 24'sd0);
        send_point(MODE_QUERY, '0, {1'b1, {CB-1{1'b0}}}, '0);
        send_point(MODE_QUERY, '0, 24'sd600, -24'sd700);
        send_point(MODE_SPARE, 24'sd77, 24'sd88, -24'sd99);
        send_point(MODE_CLEAR, 24'sd5, 24'sd5, 24'sd5);
        send_point(MODE_QUERY, 24'sd9000, 24'sd100, 24'sd9000);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_LAYER_COUNT, '0);
        write_reg(CFG_SECTOR_COUNT, '0);
        write_reg(CFG_MAX_HEIGHT, '0);
        write_reg(CFG_MIN_RADIUS, '0);
        write_reg(CFG_MARGIN, 32'h0000_FFFF);
        send_point(MODE_INSERT, 24'sd100, 24'sd50, 24'sd100);
        send_point(MODE_QUERY, 24'sd100, 24'sd1, 24'sd100);
        send_point(MODE_QUERY, 24'sd100, 24'sd0, 24'sd100);
        write_reg(CFG_LAYER_COUNT, 32'h0000_007F);
        write_reg(CFG_SECTOR_COUNT, 32'h0000_007F);
        write_reg(CFG_LAYER_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_HEIGHT, 32'h007F_FFFF);
        write_reg(CFG_MARGIN, '0);
        write_reg(CFG_MIN_RADIUS, 32'h0000_FFFF);
        send_point(MODE_INSERT, '0, {1'b0, {CB-1{1'b1}}}, '0);
        send_point(MODE_INSERT, -24'sd3, 24'sd40, 24'sd4);
        send_point(MODE_QUERY, 24'sd70000, 24'sd40, 24'sd1);
        write_reg(CFG_LAYER_SCALE, '0);
        send_point(MODE_QUERY, 24'sd7, 24'sd40000, -24'sd7);
    endtask

    // Random phases: a fresh register setting, then mostly insert/query traffic.
    task automatic test_random_phases(input int phases, input int per_phase);
        logic [MODE_W-1:0] m;
        int pick;
        for (int p = 0; p < phases; p++) begin
            write_reg(CFG_LAYER_COUNT, $urandom_range(0, 127));
            write_reg(CFG_SECTOR_COUNT, $urandom_range(3) == 0 ? $urandom_range(0, 127)
                                                                : $urandom_range(1, 64));
            write_reg(CFG_LAYER_SCALE, $urandom_range(3) == 0 ? $urandom
                                                              : $urandom_range(0, 1 << 18));
            write_reg(CFG_MAX_HEIGHT, $urandom_range(1) ? $urandom_range(0, 23'h7FFFFF)
                                                        : $urandom_range(0, 8000));
            write_reg(CFG_MARGIN, $urandom_range(3) == 0 ? $urandom_range(0, 16'hFFFF)
                                                         : $urandom_range(0, 200));
            write_reg(CFG_MIN_RADIUS, $urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15));
            if (p == phases / 2) begin
                send_point(MODE_INSERT, 24'sd1, 24'sd1, 24'sd1);
                wait_drained();
            end
            for (int k = 0; k < per_phase; k++) begin
                pick = $urandom_range(99);
                m = pick < 1 ? MODE_CLEAR : pick < 3 ? MODE_SPARE : pick < 50 ? MODE_INSERT
                                                                               : MODE_QUERY;
                if (m == MODE_QUERY && $urandom_range(1))
                    send_point(m, CB'(last_x + $signed(CB'($urandom_range(0, 64))) - 32),
                               last_y,
                               CB'(last_z + $signed(CB'($urandom_range(0, 64))) - 32));
                else
                    send_point(m, pick_coord(), pick_coord(), pick_coord());
            end
        end
    endtask

    task automatic test_no_idle_stretch();
        idling_on = 1'b0;
        for (int k = 0; k < 150; k++)
            send_point($urandom_range(1) ? MODE_INSERT : MODE_QUERY,
                       pick_coord(), pick_coord(), pick_coord());
        idling_on = 1'b1;
    endtask

    initial begin
        start = 1'b0;
        i_mode = MODE_CLEAR;
        i_x_coord = '0;
        i_y_coord = '0;
        i_z_coord = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        foreach (envelope[i]) envelope[i] = '0;
        envelope_built = 1'b0;
        layer_count_q = RST_LAYER_COUNT;
        sector_count_q = RST_SECTOR_COUNT;
        layer_scale_q = RST_LAYER_SCALE;
        max_height_q = RST_MAX_HEIGHT;
        margin_q = RST_MARGIN;
        min_radius_q = RST_MIN_RADIUS;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_no_idle_stretch();
        test_random_phases(10, 150);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, sized for every item taking a full table clear.
    initial begin
        #300ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
